// ===== hw/rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned EpsW     = 16;
  localparam int unsigned RootW    = 24;            // floor(sqrt(2^31 * 2^16)) < 2^24
  localparam int unsigned RadW     = 2 * RootW;     // radicand bits, two consumed per step
  localparam int unsigned SqRemW   = RootW + 3;
  localparam int unsigned NbW      = DataW + 2;     // -b, exact
  localparam int unsigned NumW     = DataW + 3;     // -b +- sqrt, signed
  localparam int unsigned NumMagW  = DataW + 1;
  localparam int unsigned DivBits  = NumMagW + FracW - 1;
  localparam logic [EpsW-1:0] EpsReset = 16'd6;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_LOW_DISC = 2'd1,
    ST_NO_ROOT  = 2'd2,
    ST_ZERO_A   = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;   // meaningful when early is set
    logic             early;    // outcome fixed at decode
    logic             single;   // discriminant equals epsilon
    logic             a_neg;
    logic [DataW-1:0] a_mag;
  } ctl_t;

  typedef struct packed {
    ctl_t                   ctl;
    logic signed [NbW-1:0]  nb;
    logic [RadW-1:0]        rad;
    logic [SqRemW-1:0]      rem;
    logic [RootW-1:0]       root;
  } sq_t;

  typedef struct packed {
    logic               neg;
    logic [DataW-1:0]   rem;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] quo;
  } lane_t;

  typedef struct packed {
    ctl_t            ctl;
    lane_t [1:0]     lane;
  } div_t;

endpackage

// ===== hw/rtl/qrs_sqrt_stage.sv =====
`timescale 1ns / 1ps
module qrs_sqrt_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qrs_pkg::sq_t  data_i,
  output logic          valid_o,
  output qrs_pkg::sq_t  data_o
);
  import qrs_pkg::*;

  logic              valid_q;
  sq_t               data_q, data_d;
  logic [SqRemW-1:0] rem_s, trial;
  logic              ge;

  // one result bit per stage
  always_comb begin
    rem_s  = {data_i.rem[SqRemW-3:0], data_i.rad[RadW-1 -: 2]};
    trial  = {1'b0, data_i.root, 2'b01};
    ge     = rem_s >= trial;
    data_d = data_i;
    data_d.rad  = {data_i.rad[RadW-3:0], 2'b00};
    data_d.rem  = ge ? rem_s - trial : rem_s;
    data_d.root = {data_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/qrs_div_stage.sv =====
`timescale 1ns / 1ps
module qrs_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qrs_pkg::div_t data_i,
  output logic          valid_o,
  output qrs_pkg::div_t data_o
);
  import qrs_pkg::*;

  logic          valid_q;
  div_t          data_q, data_d;
  logic [DataW:0] rem_s [2];
  logic [DataW:0] diff [2];
  logic [1:0]     ge;

  // restoring division, one quotient bit per stage in both lanes
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 2; l++) begin
      rem_s[l] = {data_i.lane[l].rem, data_i.lane[l].num[DivBits-1]};
      diff[l]  = rem_s[l] - {1'b0, data_i.ctl.a_mag};
      ge[l]    = rem_s[l] >= {1'b0, data_i.ctl.a_mag};
      data_d.lane[l].rem = ge[l] ? diff[l][DataW-1:0] : rem_s[l][DataW-1:0];
      data_d.lane[l].num = {data_i.lane[l].num[DivBits-2:0], 1'b0};
      data_d.lane[l].quo = {data_i.lane[l].quo[DivBits-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/qrs_select.sv =====
`timescale 1ns / 1ps
module qrs_select (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qrs_pkg::div_t               data_i,
  input  logic [qrs_pkg::EpsW-1:0]    eps_i,
  output logic                        valid_o,
  output logic [qrs_pkg::DataW-1:0]   distance_o,
  output qrs_pkg::status_e            status_o
);
  import qrs_pkg::*;

  logic             valid_q;
  ctl_t             ctl_q;
  logic [DataW-1:0] k1_q, k2_q, k1_d, k2_d;
  logic signed [DataW-1:0] k1s, k2s, eps_s;
  logic             ok1, ok2;

  function automatic logic [DataW-1:0] sat(input logic neg, input logic [DivBits-1:0] q);
    logic [DivBits-1:0] lim;
    logic [DivBits-1:0] qs;
    lim = neg ? (DivBits'(1) << (DataW - 1)) : ((DivBits'(1) << (DataW - 1)) - DivBits'(1));
    qs  = (q > lim) ? lim : q;
    return neg ? (DataW'(0) - qs[DataW-1:0]) : qs[DataW-1:0];
  endfunction

  always_comb begin
    k1_d = sat(data_i.lane[0].neg ^ data_i.ctl.a_neg, data_i.lane[0].quo);
    k2_d = sat(data_i.lane[1].neg ^ data_i.ctl.a_neg, data_i.lane[1].quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= data_i.ctl;
      k1_q  <= k1_d;
      k2_q  <= k2_d;
    end
  end

  // pass early outcomes; a single root is taken without the epsilon test, else the nearest root strictly above epsilon
  always_comb begin
    k1s   = $signed(k1_q);
    k2s   = $signed(k2_q);
    eps_s = $signed({{(DataW-EpsW){1'b0}}, eps_i});
    ok1   = k1s > eps_s;
    ok2   = k2s > eps_s;
    distance_o = '0;
    status_o   = ST_HIT;
    if (ctl_q.early) begin
      status_o = ctl_q.status;
    end else if (ctl_q.single) begin
      distance_o = k1_q;
    end else if (ok1 && ok2) begin
      distance_o = (k1s < k2s) ? k1_q : k2_q;
    end else if (ok1) begin
      distance_o = k1_q;
    end else if (ok2) begin
      distance_o = k2_q;
    end else begin
      status_o = ST_NO_ROOT;
    end
  end

  assign valid_o = valid_q;
endmodule

// ===== hw/rtl/ray_quadratic_root_select_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------
// in       | in        | in_valid_i / in_stall_o | coef_a_i, coef_b_i, discriminant_i
// out      | out       | out_valid_o/ out_stall_i| distance_o, status_o
// config   | in        | epsilon_we_i            | epsilon_wdata_i
//
// One item enters per cycle unless in_stall_o is set; the path is decode, 24 square-root stages
// (one root bit each), numerator stage, 48 divider stages (one quotient bit each,
// two lanes sharing the divisor), saturate stage, then a two-entry output buffer.
// Reset clears all valid bits and the buffer, and sets epsilon to 6.
// The whole pipe advances when the output buffer is not full, so in_stall_o comes
// straight from a register; a waiting result does not block intake until two wait.
module ray_quadratic_root_select_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          coef_a_i,
  input  logic signed [31:0]          coef_b_i,
  input  logic signed [31:0]          discriminant_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          distance_o,
  output logic [1:0]                  status_o,
  input  logic                        epsilon_we_i,
  input  logic [15:0]                 epsilon_wdata_i
);
  import qrs_pkg::*;

  logic [EpsW-1:0] eps_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (epsilon_we_i) begin
      eps_q <= epsilon_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // pipeline advance: hold everything only when the buffer is full
  // ---------------------------------------------------------------
  logic [1:0] cnt_q, cnt_d;
  logic       en;
  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------
  // decode: magnitudes, early outcomes, square-root seed
  // ---------------------------------------------------------------
  logic             a_neg, d_neg;
  logic [DataW-1:0] a_mag, d_mag, eps_ext;
  sq_t              dec_d;
  logic             dec_v_q;
  sq_t              dec_q;

  always_comb begin
    a_neg   = coef_a_i[DataW-1];
    d_neg   = discriminant_i[DataW-1];
    a_mag   = a_neg ? DataW'(0) - coef_a_i : coef_a_i;
    d_mag   = d_neg ? DataW'(0) - discriminant_i : discriminant_i;
    eps_ext = {{(DataW-EpsW){1'b0}}, eps_q};
    dec_d            = '0;
    dec_d.ctl.a_neg  = a_neg;
    dec_d.ctl.a_mag  = a_mag;
    dec_d.ctl.single = (d_mag == eps_ext);
    dec_d.nb         = NbW'(0) - {{(NbW-DataW){coef_b_i[DataW-1]}}, coef_b_i};
    // the single-root case runs with a zero radicand, so its root is zero
    dec_d.rad        = dec_d.ctl.single ? '0 : {d_mag[RadW-FracW-1:0], {FracW{1'b0}}};
    if (d_neg || d_mag < eps_ext) begin
      dec_d.ctl.early  = 1'b1;
      dec_d.ctl.status = ST_LOW_DISC;
    end else if (a_mag == '0) begin
      dec_d.ctl.early  = 1'b1;
      dec_d.ctl.status = ST_ZERO_A;
    end else begin
      dec_d.ctl.early  = 1'b0;
      dec_d.ctl.status = ST_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_v_q <= 1'b0;
    end else if (en) begin
      dec_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec_q <= dec_d;
    end
  end

  // ---------------------------------------------------------------
  // square root chain
  // ---------------------------------------------------------------
  logic sq_v [RootW+1];
  sq_t  sq_d [RootW+1];
  assign sq_v[0] = dec_v_q;
  assign sq_d[0] = dec_q;

  for (genvar g = 0; g < RootW; g++) begin : g_sq
    qrs_sqrt_stage u_sq (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .data_i  (sq_d[g]),
      .valid_o (sq_v[g+1]),
      .data_o  (sq_d[g+1])
    );
  end

  // ---------------------------------------------------------------
  // numerators -b + s and -b - s in sign/magnitude
  // ---------------------------------------------------------------
  logic signed [NumW-1:0] n1, n2, nb_x, s_x;
  logic [NumW-1:0]        m1, m2;
  div_t                   num_d;
  logic                   num_v_q;
  div_t                   num_q;

  always_comb begin
    nb_x = {{(NumW-NbW){sq_d[RootW].nb[NbW-1]}}, sq_d[RootW].nb};
    s_x  = {{(NumW-RootW){1'b0}}, sq_d[RootW].root};
    n1   = nb_x + s_x;
    n2   = nb_x - s_x;
    m1   = n1[NumW-1] ? NumW'(0) - n1 : n1;
    m2   = n2[NumW-1] ? NumW'(0) - n2 : n2;
    num_d              = '0;
    num_d.ctl          = sq_d[RootW].ctl;
    num_d.lane[0].neg  = n1[NumW-1];
    num_d.lane[1].neg  = n2[NumW-1];
    num_d.lane[0].num  = {m1[NumMagW-1:0], {(FracW-1){1'b0}}};
    num_d.lane[1].num  = {m2[NumMagW-1:0], {(FracW-1){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else if (en) begin
      num_v_q <= sq_v[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
    end
  end

  // ---------------------------------------------------------------
  // divider chain: numerator * 2^(frac-1) / |a|
  // ---------------------------------------------------------------
  logic dv_v [DivBits+1];
  div_t dv_d [DivBits+1];
  assign dv_v[0] = num_v_q;
  assign dv_d[0] = num_q;

  for (genvar g = 0; g < DivBits; g++) begin : g_div
    qrs_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[g]),
      .data_i  (dv_d[g]),
      .valid_o (dv_v[g+1]),
      .data_o  (dv_d[g+1])
    );
  end

  // ---------------------------------------------------------------
  // saturate and choose
  // ---------------------------------------------------------------
  logic             sel_v;
  logic [DataW-1:0] sel_dist;
  status_e          sel_st;

  qrs_select u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_v[DivBits]),
    .data_i     (dv_d[DivBits]),
    .eps_i      (eps_q),
    .valid_o    (sel_v),
    .distance_o (sel_dist),
    .status_o   (sel_st)
  );

  // ---------------------------------------------------------------
  // two-entry output buffer
  // ---------------------------------------------------------------
  logic [DataW+1:0] ent_q [2];
  logic             wp_q, rp_q;
  logic             push, pop;

  assign push = en && sel_v;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= {sel_st, sel_dist};
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign distance_o  = ent_q[rp_q][DataW-1:0];
  assign status_o    = ent_q[rp_q][DataW+1:DataW];

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output buffer count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2 && in_stall_o))
    else $error("full buffer must hold the pipe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_HIT) |-> (distance_o == '0))
    else $error("distance must be zero unless hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q == rp_q) |-> (cnt_q == 2'd0 || cnt_q == 2'd2))
    else $error("buffer pointers disagree with count");
endmodule

// ===== tb/ray_quadratic_root_select_top_tb.sv =====
`timescale 1ns / 1ps
module ray_quadratic_root_select_top_tb;
  import qrs_pkg::*;

  // One expected result: the chosen distance and its status code.
  typedef struct {
    logic signed [31:0] distance;
    status_e            st;
  } root_result_t;

  // One row of the directed table. Where `typed` is set, the expected result is
  // written in directly; otherwise the root predictor supplies it.
  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] d;
    bit                 typed;
    logic signed [31:0] distance;
    status_e            st;
  } ray_row_t;

  localparam int unsigned Q1   = 32'h0001_0000;  // 1.0 in Q16.16
  localparam int unsigned Drain = 100;           // a little past the pipeline depth

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] coef_a_i = '0;
  logic signed [31:0] coef_b_i = '0;
  logic signed [31:0] discriminant_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] distance_o;
  logic [1:0]         status_o;
  logic               epsilon_we_i = 1'b0;
  logic [15:0]        epsilon_wdata_i = '0;

  root_result_t pending_roots[$];
  logic [15:0]  eps_shadow = EpsReset;
  int           n_items, n_checked, n_hits, n_errors;
  int           stall_mode;

  ray_quadratic_root_select_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .coef_a_i        (coef_a_i),
    .coef_b_i        (coef_b_i),
    .discriminant_i  (discriminant_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_o      (distance_o),
    .status_o        (status_o),
    .epsilon_we_i    (epsilon_we_i),
    .epsilon_wdata_i (epsilon_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the pipe hangs.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Root predictor
  // ---------------------------------------------------------------------------

  // floor(sqrt(x)), two radicand bits per step.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned rem, root, trial;
    rem  = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem   = (rem << 2) | ((x >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // num / (2a) in Q16.16: magnitude truncated, then saturated to 32 bits signed.
  function automatic longint half_quotient(input longint num, input longint a);
    longint unsigned nmag, amag, q, lim;
    bit              neg;
    nmag = (num < 0) ? -num : num;
    amag = (a < 0) ? -a : a;
    neg  = (num < 0) != (a < 0);
    q    = (nmag << (FracW - 1)) / amag;
    lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic root_result_t nearest_root(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] d);
    root_result_t    r;
    longint          la, lb, ld, eps, k1, k2;
    longint unsigned s;
    bit              ok1, ok2;
    la  = a;
    lb  = b;
    ld  = d;
    eps = eps_shadow;
    r.distance = '0;
    if (ld < eps) begin
      r.st = ST_LOW_DISC;
    end else if (la == 0) begin
      r.st = ST_ZERO_A;
    end else if (ld == eps) begin
      r.distance = half_quotient(-lb, la);
      r.st       = ST_HIT;
    end else begin
      s   = int_sqrt(longint'(ld) << FracW);
      k1  = half_quotient(-lb + longint'(s), la);
      k2  = half_quotient(-lb - longint'(s), la);
      ok1 = k1 > eps;
      ok2 = k2 > eps;
      r.st = ST_HIT;
      if (ok1 && ok2)  r.distance = (k1 < k2) ? k1 : k2;
      else if (ok1)    r.distance = k1;
      else if (ok2)    r.distance = k2;
      else             r.st = ST_NO_ROOT;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle patterns
  // ---------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall: switch between no stalls, light stalls and heavy bursts.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 20);
      default: begin
        if (out_stall_i) out_stall_i <= ($urandom_range(0, 99) < 90);
        else             out_stall_i <= ($urandom_range(0, 99) < 8);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    root_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result distance=%h status=%0d",
                 $time, distance_o, status_o);
        n_errors++;
      end else begin
        exp_r = pending_roots.pop_front();
        n_checked++;
        if (exp_r.st == ST_HIT) n_hits++;
        if (status_o !== exp_r.st) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, exp_r.st, status_o);
          n_errors++;
        end
        if (distance_o !== exp_r.distance) begin
          $display("%0t: distance mismatch expected %h actual %h",
                   $time, exp_r.distance, distance_o);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Present one item after a random gap, hold it until accepted, then queue
  // its expectation (typed in, or from the predictor).
  task automatic send_item(input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic signed [31:0] d, input bit typed,
                           input root_result_t typed_r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    coef_a_i       = a;
    coef_b_i       = b;
    discriminant_i = d;
    do @(posedge clk_i); while (in_stall_o);
    pending_roots.push_back(typed ? typed_r : nearest_root(a, b, d));
    n_items++;
  endtask

  // Drop valid, let every expected result drain plus the pipe depth, then
  // write epsilon.
  task automatic write_epsilon(input logic [15:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
    epsilon_we_i    = 1'b1;
    epsilon_wdata_i = value;
    eps_shadow      = value;
    @(negedge clk_i);
    epsilon_we_i = 1'b0;
  endtask

  // Signed magnitude up to the given bound, random sign.
  function automatic logic signed [31:0] rand_signed(input int unsigned bound);
    logic signed [31:0] v;
    v = $urandom_range(0, bound);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Random item: mostly modest coefficients so that roots land in range,
  // with full-width noise mixed in.
  task automatic random_item(output logic signed [31:0] a, output logic signed [31:0] b,
                             output logic signed [31:0] d);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)      a = '0;
    else if (r < 5)  a = rand_signed(4 * Q1);
    else if (r < 8)  a = rand_signed(32'h0100_0000);
    else             a = $urandom;
    b = ($urandom_range(0, 1)) ? rand_signed(8 * Q1) : $urandom;
    r = $urandom_range(0, 9);
    case (r)
      0: d = $urandom | 32'h8000_0000;
      1: d = $urandom_range(0, eps_shadow);
      2: d = eps_shadow;
      3, 4, 5, 6: d = $urandom_range(eps_shadow + 1, 16 * Q1);
      7: d = eps_shadow + $urandom_range(1, 4);
      default: d = $urandom & 32'h7FFF_FFFF;
    endcase
  endtask

  ray_row_t directed[] = '{
    // low discriminant always wins
    '{32'sh0001_0000, 32'sh0, -32'sd1,        1'b1, 32'sh0, ST_LOW_DISC},
    '{32'sh0001_0000, 32'sh0, 32'sd5,         1'b1, 32'sh0, ST_LOW_DISC},
    '{32'sh0001_0000, 32'sh0, 32'sh8000_0000, 1'b1, 32'sh0, ST_LOW_DISC},
    '{32'sh0,         32'sh0, -32'sd1,        1'b1, 32'sh0, ST_LOW_DISC},
    // zero a
    '{32'sh0, 32'sh0001_0000, 32'sd100,       1'b1, 32'sh0, ST_ZERO_A},
    '{32'sh0, 32'sh0,         32'sd6,         1'b1, 32'sh0, ST_ZERO_A},
    '{32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh0, ST_ZERO_A},
    // discriminant equal to epsilon: single root -b/(2a), sign kept
    '{32'sh0001_0000, -32'sh0002_0000, 32'sd6, 1'b1, 32'sh0001_0000, ST_HIT},
    '{32'sh0001_0000, 32'sh0002_0000,  32'sd6, 1'b1, -32'sh0001_0000, ST_HIT},
    '{32'sd1, 32'sh8000_0000, 32'sd6,          1'b1, 32'sh7FFF_FFFF, ST_HIT},
    '{32'sd1, 32'sh7FFF_FFFF, 32'sd6,          1'b1, 32'sh8000_0000, ST_HIT},
    '{32'sh8000_0000, 32'sh0, 32'sd6,          1'b1, 32'sh0, ST_HIT},
    // two roots, one root, none; equal roots; extremes
    '{32'sh0001_0000, -32'sh0003_0000, 32'sh0001_0000, 1'b0, 32'sh0, ST_HIT},
    '{32'sh0001_0000, 32'sh0, 32'sh0004_0000,          1'b0, 32'sh0, ST_HIT},
    '{32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,  1'b0, 32'sh0, ST_HIT},
    '{-32'sh0001_0000, -32'sh0003_0000, 32'sh0001_0000, 1'b0, 32'sh0, ST_HIT},
    '{32'sh0001_0000, -32'sh0002_0000, 32'sd7,         1'b0, 32'sh0, ST_HIT},
    '{32'sh0001_0000, -32'sd12, 32'sd7,                1'b0, 32'sh0, ST_HIT},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,  1'b0, 32'sh0, ST_HIT},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,  1'b0, 32'sh0, ST_HIT},
    '{32'sd1, 32'sh0, 32'sh7FFF_FFFF,                  1'b0, 32'sh0, ST_HIT},
    '{-32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,         1'b0, 32'sh0, ST_HIT},
    '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'sh5555_5555,  1'b0, 32'sh0, ST_HIT}
  };

  initial begin
    logic signed [31:0] a, b, d;
    root_result_t       tr;
    logic [15:0]        eps_plan[5];
    n_items    = 0;
    n_checked  = 0;
    n_hits     = 0;
    n_errors   = 0;
    stall_mode = 0;
    eps_plan   = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, EpsReset};

    // Hold reset low, then release it on a falling edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table runs with the reset value of epsilon.
    foreach (directed[i]) begin
      tr.distance = directed[i].distance;
      tr.st       = directed[i].st;
      send_item(directed[i].a, directed[i].b, directed[i].d, directed[i].typed, tr);
    end

    // Random phases, each under a different epsilon.
    foreach (eps_plan[p]) begin
      write_epsilon(eps_plan[p]);
      repeat (256) begin
        random_item(a, b, d);
        send_item(a, b, d, 1'b0, tr);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);

    $display("Sent %0d items over 6 epsilon settings; checked %0d results, %0d hits.",
             n_items, n_checked, n_hits);
    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt_stage.sv
hw/rtl/qrs_div_stage.sv
hw/rtl/qrs_select.sv
hw/rtl/ray_quadratic_root_select_top.sv
tb/ray_quadratic_root_select_top_tb.sv
